@@ hw/rtl/fdtw_pkg.sv @@
// Shared types, codes and constants for the structure block token walker.
package fdtw_pkg;

    localparam int unsigned C_POS_BITS   = 24;
    localparam int unsigned C_DEPTH_BITS = 8;
    localparam int unsigned C_SKIP_BITS  = 30;
    localparam int unsigned C_PADDR_BITS = 3;

    localparam logic [31:0] C_PAD_ROUND  = 32'd3;
    localparam logic [C_POS_BITS:0] C_WORD_BYTES = (C_POS_BITS + 1)'(4);
    localparam logic [C_POS_BITS:0] C_PROP_HDR_BYTES = (C_POS_BITS + 1)'(12);

    localparam logic signed [C_DEPTH_BITS-1:0] C_DEPTH_MAX = {1'b0, {(C_DEPTH_BITS-1){1'b1}}};
    localparam logic signed [C_DEPTH_BITS-1:0] C_DEPTH_MIN = {1'b1, {(C_DEPTH_BITS-1){1'b0}}};

    // token codes in token position
    localparam logic [31:0] C_TOK_BEGIN   = 32'd1;
    localparam logic [31:0] C_TOK_ENDNODE = 32'd2;
    localparam logic [31:0] C_TOK_PROP    = 32'd3;
    localparam logic [31:0] C_TOK_NOP     = 32'd4;
    localparam logic [31:0] C_TOK_END     = 32'd9;

    // register address, compared with bit 2 of the byte address
    localparam logic C_REG_STRUCT_SIZE = 1'b0;

    typedef enum logic [2:0] {
        MODE_TOKEN = 3'd0,
        MODE_NAME  = 3'd1,
        MODE_PLEN  = 3'd2,
        MODE_NOFF  = 3'd3,
        MODE_SKIP  = 3'd4,
        MODE_DONE  = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        EV_BEGIN   = 2'd0,
        EV_ENDNODE = 2'd1,
        EV_PROP    = 2'd2,
        EV_END     = 2'd3
    } t_event;

    typedef enum logic [1:0] {
        CAUSE_END_TOKEN = 2'd0,
        CAUSE_UNKNOWN   = 2'd1,
        CAUSE_EXHAUSTED = 2'd2,
        CAUSE_TRUNCATED = 2'd3
    } t_cause;

    typedef struct packed {
        logic [31:0] word;
        logic        start_req;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]                     event_res;
        logic signed [C_DEPTH_BITS-1:0] depth;
        logic [C_POS_BITS-1:0]          offset;
        logic [31:0]                    prop_length;
        logic [31:0]                    name_offset;
        logic [1:0]                     end_cause;
        logic                           last;
    } t_out_beat;

endpackage

@@ hw/rtl/fdt_structure_token_walker.sv @@
// Structure block token walker: one 32-bit word in, up to two token events out.
// An event is in the output queue the cycle after its word beat is taken.
// Throughput: one word beat per cycle while input ready is high; a word that yields two
// events (an event plus the block-exhausted end) takes two output queue entries.
// Input ready drops only while the four-entry output queue has fewer than two free slots.
// Reset (i_rst_n low, synchronous) empties the queue and clears mode, position, depth,
// skip count and struct_size.
module fdt_structure_token_walker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // word beats
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  fdtw_pkg::t_in_beat                    i_in_data,
    // event beats
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output fdtw_pkg::t_out_beat                   o_out_data,
    // register port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [fdtw_pkg::C_PADDR_BITS-1:0]     paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import fdtw_pkg::*;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR   = $clog2(QDEPTH);

    // ---------------------------------------------------------------
    // Register port: struct_size only. Always ready.
    // ---------------------------------------------------------------
    logic [C_POS_BITS-1:0] r_struct_size;
    logic                  cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign prdata = (paddr[2] == C_REG_STRUCT_SIZE)
                  ? {{(32 - C_POS_BITS){1'b0}}, r_struct_size} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_struct_size <= '0;
        end else if (cfg_wr && paddr[2] == C_REG_STRUCT_SIZE) begin
            r_struct_size <= pwdata[C_POS_BITS-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Walker state
    // ---------------------------------------------------------------
    t_mode                          r_mode, n_mode;
    logic [C_POS_BITS-1:0]          r_pos, n_pos;
    logic signed [C_DEPTH_BITS-1:0] r_depth, n_depth;
    logic [C_SKIP_BITS-1:0]         r_skip, n_skip;
    logic [31:0]                    r_held_len, n_held_len;
    logic [C_POS_BITS-1:0]          r_item_start, n_item_start;  // no reset, written first

    logic in_take;
    assign in_take = i_in_valid & o_in_ready;

    // start_req clears the state before the word is looked at
    t_mode                          mode_e;
    logic [C_POS_BITS-1:0]          pos_e;
    logic signed [C_DEPTH_BITS-1:0] depth_e;
    logic [C_SKIP_BITS-1:0]         skip_e;
    logic [31:0]                    held_len_e;
    logic [31:0]                    word;

    assign word       = i_in_data.word;
    assign mode_e     = i_in_data.start_req ? MODE_TOKEN : r_mode;
    assign pos_e      = i_in_data.start_req ? '0 : r_pos;
    assign depth_e    = i_in_data.start_req ? '0 : r_depth;
    assign skip_e     = i_in_data.start_req ? '0 : r_skip;
    assign held_len_e = i_in_data.start_req ? '0 : r_held_len;

    // position arithmetic, one bit of headroom for the compares
    logic [C_POS_BITS:0]   sum4, sum12, next_sum4;
    logic [C_POS_BITS-1:0] pos_inc4, pos_inc12;
    logic                  tok_fit, hdr_fit, adv;

    assign sum4      = {1'b0, pos_e} + C_WORD_BYTES;
    assign sum12     = {1'b0, pos_e} + C_PROP_HDR_BYTES;
    assign pos_inc4  = sum4[C_POS_BITS]  ? '1 : sum4[C_POS_BITS-1:0];
    assign pos_inc12 = sum12[C_POS_BITS] ? '1 : sum12[C_POS_BITS-1:0];
    assign tok_fit   = sum4  <= {1'b0, r_struct_size};
    assign hdr_fit   = sum12 <= {1'b0, r_struct_size};

    // name: stop at the first word holding a zero byte
    logic zero_byte;
    assign zero_byte = (word[31:24] == 8'd0) || (word[23:16] == 8'd0) ||
                       (word[15:8] == 8'd0)  || (word[7:0] == 8'd0);

    // padded data length in words, modulo 2^32 before the shift
    logic [31:0]            pad_len;
    logic [C_SKIP_BITS-1:0] skip_new, skip_dec;
    assign pad_len  = r_held_len + C_PAD_ROUND;
    assign skip_new = pad_len[31:2];
    assign skip_dec = (skip_e != '0) ? skip_e - 1'b1 : '0;

    // every mode but done/token-out-of-room advances the position by a word
    assign adv = ((mode_e == MODE_TOKEN) && tok_fit) || (mode_e == MODE_NAME) ||
                 (mode_e == MODE_PLEN) || (mode_e == MODE_NOFF) || (mode_e == MODE_SKIP);

    // mode before the block-exhausted check
    t_mode mode_pre;

    always_comb begin
        mode_pre = mode_e;
        unique case (mode_e)
            MODE_TOKEN: begin
                if (!tok_fit) begin
                    mode_pre = MODE_DONE;
                end else begin
                    case (word)
                        C_TOK_BEGIN:   mode_pre = MODE_NAME;
                        C_TOK_ENDNODE: mode_pre = MODE_TOKEN;
                        C_TOK_PROP:    mode_pre = hdr_fit ? MODE_PLEN : MODE_DONE;
                        C_TOK_NOP:     mode_pre = MODE_TOKEN;
                        default:       mode_pre = MODE_DONE;   // end token or unknown
                    endcase
                end
            end
            MODE_NAME: mode_pre = zero_byte ? MODE_TOKEN : MODE_NAME;
            MODE_PLEN: mode_pre = MODE_NOFF;
            MODE_NOFF: mode_pre = (skip_new != '0) ? MODE_SKIP : MODE_TOKEN;
            MODE_SKIP: mode_pre = (skip_dec == '0) ? MODE_TOKEN : MODE_SKIP;
            default:   mode_pre = MODE_DONE;
        endcase
    end

    // datapath next values
    logic exhaust;

    always_comb begin
        n_pos        = adv ? pos_inc4 : pos_e;
        n_depth      = depth_e;
        n_skip       = skip_e;
        n_held_len   = held_len_e;
        n_item_start = r_item_start;
        if (mode_e == MODE_TOKEN && tok_fit) begin
            if (word == C_TOK_BEGIN && depth_e != C_DEPTH_MAX) begin
                n_depth = depth_e + 1'b1;
            end
            if (word == C_TOK_ENDNODE && depth_e != C_DEPTH_MIN) begin
                n_depth = depth_e - 1'b1;
            end
            if (word == C_TOK_PROP) begin
                n_item_start = pos_inc12;
            end
        end
        if (mode_e == MODE_PLEN) begin
            n_held_len = word;
        end
        if (mode_e == MODE_NOFF) begin
            n_skip = skip_new;
        end
        if (mode_e == MODE_SKIP) begin
            n_skip = skip_dec;
        end
    end

    // after the word: expecting a token with less than a word left ends the walk
    assign next_sum4 = {1'b0, n_pos} + C_WORD_BYTES;
    assign exhaust   = (mode_pre == MODE_TOKEN) && (next_sum4 > {1'b0, r_struct_size});
    assign n_mode    = exhaust ? MODE_DONE : mode_pre;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_TOKEN;
            r_pos      <= '0;
            r_depth    <= '0;
            r_skip     <= '0;
            r_held_len <= '0;
        end else if (in_take) begin
            r_mode     <= n_mode;
            r_pos      <= n_pos;
            r_depth    <= n_depth;
            r_skip     <= n_skip;
            r_held_len <= n_held_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item_start <= n_item_start;
        end
    end

    // ---------------------------------------------------------------
    // Event generation: primary event (ev_a) and exhausted end (ev_b)
    // ---------------------------------------------------------------
    t_out_beat ev_a, ev_b;
    logic      ev_a_vld;

    always_comb begin
        ev_a             = '0;
        ev_a.depth       = n_depth;
        ev_a_vld         = 1'b0;
        if (mode_e == MODE_TOKEN) begin
            ev_a_vld = 1'b1;
            if (!tok_fit) begin
                ev_a.event_res = EV_END;
                ev_a.offset    = pos_e;
                ev_a.end_cause = CAUSE_EXHAUSTED;
            end else begin
                case (word)
                    C_TOK_BEGIN: begin
                        ev_a.event_res = EV_BEGIN;
                        ev_a.offset    = n_pos;
                    end
                    C_TOK_ENDNODE: begin
                        ev_a.event_res = EV_ENDNODE;
                    end
                    C_TOK_PROP: begin
                        ev_a_vld       = !hdr_fit;
                        ev_a.event_res = EV_END;
                        ev_a.offset    = pos_e;
                        ev_a.end_cause = CAUSE_TRUNCATED;
                    end
                    C_TOK_NOP: begin
                        ev_a_vld = 1'b0;
                    end
                    C_TOK_END: begin
                        ev_a.event_res = EV_END;
                        ev_a.offset    = pos_e;
                        ev_a.end_cause = CAUSE_END_TOKEN;
                    end
                    default: begin
                        ev_a.event_res = EV_END;
                        ev_a.offset    = pos_e;
                        ev_a.end_cause = CAUSE_UNKNOWN;
                    end
                endcase
            end
        end else if (mode_e == MODE_NOFF) begin
            ev_a_vld         = 1'b1;
            ev_a.event_res   = EV_PROP;
            ev_a.offset      = r_item_start;
            ev_a.prop_length = held_len_e;
            ev_a.name_offset = word;
        end
        ev_a.last = !exhaust;

        ev_b           = '0;
        ev_b.event_res = EV_END;
        ev_b.depth     = n_depth;
        ev_b.offset    = n_pos;
        ev_b.end_cause = CAUSE_EXHAUSTED;
        ev_b.last      = 1'b1;
    end

    // ---------------------------------------------------------------
    // Output queue: four entries, up to two pushed per word beat
    // ---------------------------------------------------------------
    t_out_beat        r_q [QDEPTH];
    logic [QPTR-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QPTR:0]    r_count;
    logic [1:0]       push_n;
    logic             pop;
    logic [QPTR-1:0]  wr_ptr1;

    assign push_n = in_take ? ({1'b0, ev_a_vld} + {1'b0, exhaust}) : 2'd0;
    assign pop    = o_out_valid & i_out_ready;
    assign wr_ptr1 = r_wr_ptr + 1'b1;

    assign o_in_ready  = r_count <= (QPTR + 1)'(QDEPTH - 2);
    assign o_out_valid = r_count != '0;
    assign o_out_data  = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_q[r_wr_ptr] <= ev_a_vld ? ev_a : ev_b;
        end
        if (push_n == 2'd2) begin
            r_q[wr_ptr1] <= ev_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QPTR'(push_n);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (QPTR + 1)'(push_n) - (QPTR + 1)'(pop);
        end
    end

endmodule
